>>> rtl/pyrf_pkg.sv
package pyrf_pkg;

    // default store bounds
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // field and register widths
    localparam int DIM_W   = 9;
    localparam int LN_W    = 18;   // holds 510*510
    localparam int POS_W   = 19;   // holds one and a half luma planes
    localparam int IDX_W   = 16;
    localparam int PIX_W   = 8;
    localparam int PROD_W  = 26;
    localparam int SUM_W   = 28;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    // register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // bt.601 full range, q16
    localparam logic signed [17:0] K_RV = 18'sd91881;
    localparam logic signed [17:0] K_GU = 18'sd22554;
    localparam logic signed [17:0] K_GV = 18'sd46802;
    localparam logic signed [17:0] K_BU = 18'sd116130;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // frame geometry derived from the size registers
    typedef struct packed
    {
        logic [DIM_W-1:0] w;
        logic [LN_W-1:0]  luma_n;
        logic [POS_W-1:0] v_start;
        logic [POS_W-1:0] total;
        logic [IDX_W-1:0] flip_init;
    } geom_t;

    // pixel tag that travels with a luma read
    typedef struct packed
    {
        logic                    valid;
        logic signed [PIX_W-1:0] dv;
        logic [IDX_W-1:0]        idx;
        logic                    group_last;
        logic                    frame_done;
    } pix_tag_t;

    function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] t);
        logic [PIX_W-1:0] r;
        begin
            if (t[SUM_W-1])
            begin
                r = '0;
            end
            else if (|t[SUM_W-2:24])
            begin
                r = '1;
            end
            else
            begin
                r = t[23:16];
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/pyrf_ram.sv
module pyrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/pyrf_cfg.sv
module pyrf_cfg
    import pyrf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output geom_t             geom,
    output logic              restart,
    output logic              busy
);

    localparam int W_EVEN = (MAX_WIDTH / 2) * 2;
    localparam int H_EVEN = (MAX_HEIGHT / 2) * 2;
    localparam int W_LIM  = (W_EVEN < 510) ? W_EVEN : 510;
    localparam int H_LIM  = (H_EVEN < 510) ? H_EVEN : 510;
    localparam logic [DIM_W-1:0] W_MAX = DIM_W'(W_LIM);
    localparam logic [DIM_W-1:0] H_MAX = DIM_W'(H_LIM);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [DIM_W-1:0] w1_reg;
    logic [LN_W-1:0]  luma1_reg;
    geom_t            geom_reg;
    logic [1:0]       settle_reg, settle_next;
    logic             wr;
    logic [DIM_W-1:0] w_eff, h_eff;

    function automatic logic [DIM_W-1:0] eff_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] lim
    );
        logic [DIM_W-1:0] e;
        begin
            e = {v[DIM_W-1:1], 1'b0};
            if (e < DIM_W'(2))
            begin
                e = DIM_W'(2);
            end
            if (e > lim)
            begin
                e = lim;
            end
            return e;
        end
    endfunction

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // a write passes the size registers, then w1/luma1, then the geometry register before use
    always_comb
    begin
        if (wr)
        begin
            settle_next = 2'd2;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            settle_reg <= 2'd2;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            settle_reg <= settle_next;
        end
    end

    assign w_eff = eff_dim(width_reg, W_MAX);
    assign h_eff = eff_dim(height_reg, H_MAX);

    always_ff @(posedge clk)
    begin
        w1_reg             <= w_eff;
        luma1_reg          <= LN_W'(w_eff) * LN_W'(h_eff);
        geom_reg.w         <= w1_reg;
        geom_reg.luma_n    <= luma1_reg;
        geom_reg.v_start   <= POS_W'(luma1_reg) + POS_W'(luma1_reg[LN_W-1:2]);
        geom_reg.total     <= POS_W'(luma1_reg) + POS_W'(luma1_reg[LN_W-1:1]);
        geom_reg.flip_init <= IDX_W'(luma1_reg) - IDX_W'({w1_reg, 1'b0});
    end

    assign geom    = geom_reg;
    assign restart = wr;
    assign busy    = (settle_reg != 2'd0);

endmodule

>>> rtl/pyrf_seq.sv
module pyrf_seq
    import pyrf_pkg::*;
#(
    parameter int LA_W       = 16,
    parameter int CA_W       = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  logic             cfg_restart,
    input  logic             cfg_busy,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] frame_byte,
    input  logic             frame_start,
    input  logic             advance,
    output logic             luma_wr_en,
    output logic [LA_W-1:0]  luma_wr_addr,
    output logic             luma_rd_en,
    output logic [LA_W-1:0]  luma_rd_addr,
    output logic             u_wr_en,
    output logic [CA_W-1:0]  u_wr_addr,
    output logic             u_rd_en,
    output logic [CA_W-1:0]  u_rd_addr,
    output pix_tag_t         tag
);

    seq_state_t              state_reg, state_next;
    logic [1:0]              k_reg, k_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [PIX_W-1:0]        ccol_reg, ccol_next;
    logic [LA_W-1:0]         row_base_reg, row_base_next;
    logic [IDX_W-1:0]        flip_reg, flip_next;
    logic                    restart_reg, restart_next;
    logic [LA_W-1:0]         grp_la_reg, grp_la_next;
    logic [IDX_W-1:0]        grp_idx_reg, grp_idx_next;
    logic signed [PIX_W-1:0] dv_reg, dv_next;
    logic                    last_reg, last_next;
    logic [CA_W-1:0]         u_addr_reg, u_addr_next;
    pix_tag_t                tag_reg, tag_next;

    logic                    accept, restart_now, issue;
    logic                    is_luma, is_u;
    logic [POS_W-1:0]        pos_eff;
    logic [PIX_W-1:0]        ccol_eff;
    logic [LA_W-1:0]         row_base_eff;
    logic [IDX_W-1:0]        flip_eff;

    assign in_ready    = (state_reg == ST_IDLE) && !cfg_busy;
    assign accept      = in_valid && in_ready;
    assign restart_now = frame_start || restart_reg;
    assign issue       = (state_reg == ST_RUN) && advance;

    assign pos_eff      = restart_now ? '0 : pos_reg;
    assign ccol_eff     = restart_now ? '0 : ccol_reg;
    assign row_base_eff = restart_now ? '0 : row_base_reg;
    assign flip_eff     = restart_now ? geom.flip_init : flip_reg;

    assign is_luma = pos_eff < POS_W'(geom.luma_n);
    assign is_u    = !is_luma && (pos_eff < geom.v_start);

    // store writes
    assign luma_wr_en   = accept && is_luma;
    assign luma_wr_addr = LA_W'(pos_eff);
    assign u_wr_en      = accept && is_u;
    assign u_wr_addr    = CA_W'(pos_eff - POS_W'(geom.luma_n));

    // group reads, one luma pixel a cycle while advance is high
    assign luma_rd_en   = issue;
    assign luma_rd_addr = grp_la_reg + (k_reg[1] ? LA_W'(geom.w) : '0) + LA_W'(k_reg[0]);
    assign u_rd_en      = issue && (k_reg == 2'd0);
    assign u_rd_addr    = u_addr_reg;

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        ccol_next     = ccol_reg;
        row_base_next = row_base_reg;
        flip_next     = flip_reg;
        restart_next  = restart_reg;
        grp_la_next   = grp_la_reg;
        grp_idx_next  = grp_idx_reg;
        dv_next       = dv_reg;
        last_next     = last_reg;
        u_addr_next   = u_addr_reg;
        tag_next      = tag_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next      = pos_eff + POS_W'(1);
                    ccol_next     = ccol_eff;
                    row_base_next = row_base_eff;
                    flip_next     = flip_eff;
                    restart_next  = 1'b0;
                    if (!is_luma && !is_u)
                    begin
                        state_next   = ST_RUN;
                        k_next       = 2'd0;
                        grp_la_next  = row_base_eff + LA_W'({ccol_eff, 1'b0});
                        grp_idx_next = flip_eff + IDX_W'(geom.w) + IDX_W'({ccol_eff, 1'b0});
                        dv_next      = {~frame_byte[PIX_W-1], frame_byte[PIX_W-2:0]};
                        last_next    = (pos_eff + POS_W'(1)) == geom.total;
                        u_addr_next  = CA_W'(pos_eff - geom.v_start);
                        if ((pos_eff + POS_W'(1)) == geom.total)
                        begin
                            restart_next = 1'b1;
                        end
                        else if (ccol_eff == geom.w[DIM_W-1:1] - PIX_W'(1))
                        begin
                            ccol_next     = '0;
                            row_base_next = row_base_eff + LA_W'({geom.w, 1'b0});
                            flip_next     = flip_eff - IDX_W'({geom.w, 1'b0});
                        end
                        else
                        begin
                            ccol_next = ccol_eff + PIX_W'(1);
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            tag_next.valid      = issue;
            tag_next.dv         = dv_reg;
            tag_next.idx        = (k_reg[1] ? grp_idx_reg - IDX_W'(geom.w) : grp_idx_reg)
                                  + IDX_W'(k_reg[0]);
            tag_next.group_last = (k_reg == 2'd3);
            tag_next.frame_done = (k_reg == 2'd3) && last_reg;
        end

        if (cfg_restart)
        begin
            restart_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            pos_reg       <= '0;
            ccol_reg      <= '0;
            row_base_reg  <= '0;
            flip_reg      <= '0;
            restart_reg   <= 1'b1;
            tag_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            ccol_reg      <= ccol_next;
            row_base_reg  <= row_base_next;
            flip_reg      <= flip_next;
            restart_reg   <= restart_next;
            tag_reg       <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_la_reg         <= grp_la_next;
        grp_idx_reg        <= grp_idx_next;
        dv_reg             <= dv_next;
        last_reg           <= last_next;
        u_addr_reg         <= u_addr_next;
    end

    assign tag = tag_reg;

endmodule

>>> rtl/pyrf_color.sv
module pyrf_color
    import pyrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pix_tag_t         tag,
    input  logic [PIX_W-1:0] y_data,
    input  logic [PIX_W-1:0] u_data,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] pixel_index,
    output logic [PIX_W-1:0] red,
    output logic [PIX_W-1:0] green,
    output logic [PIX_W-1:0] blue,
    output logic             group_last,
    output logic             frame_done
);

    logic                     s2_valid_reg;
    logic [PIX_W-1:0]         s2_y_reg;
    logic signed [PROD_W-1:0] p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic                     s2_glast_reg, s2_fdone_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [PIX_W-1:0]         out_r_reg, out_g_reg, out_b_reg;
    logic                     out_glast_reg, out_fdone_reg;

    logic signed [PIX_W-1:0]  du;
    logic signed [SUM_W-1:0]  base, t_r, t_g, t_b;

    assign advance = !out_valid_reg || out_ready;
    assign du      = {~u_data[PIX_W-1], u_data[PIX_W-2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= tag.valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // products of the chroma offsets
    always_ff @(posedge clk)
    begin
        if (advance && tag.valid)
        begin
            s2_y_reg     <= y_data;
            p_rv_reg     <= PROD_W'(K_RV) * PROD_W'(tag.dv);
            p_gu_reg     <= PROD_W'(K_GU) * PROD_W'(du);
            p_gv_reg     <= PROD_W'(K_GV) * PROD_W'(tag.dv);
            p_bu_reg     <= PROD_W'(K_BU) * PROD_W'(du);
            s2_idx_reg   <= tag.idx;
            s2_glast_reg <= tag.group_last;
            s2_fdone_reg <= tag.frame_done;
        end
    end

    assign base = $signed({{(SUM_W-PIX_W-16){1'b0}}, s2_y_reg, 16'h0000});
    assign t_r  = base + SUM_W'(p_rv_reg);
    assign t_g  = base - SUM_W'(p_gu_reg) - SUM_W'(p_gv_reg);
    assign t_b  = base + SUM_W'(p_bu_reg);

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            out_idx_reg   <= s2_idx_reg;
            out_r_reg     <= clamp_q16(t_r);
            out_g_reg     <= clamp_q16(t_g);
            out_b_reg     <= clamp_q16(t_b);
            out_glast_reg <= s2_glast_reg;
            out_fdone_reg <= s2_fdone_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = out_idx_reg;
    assign red         = out_r_reg;
    assign green       = out_g_reg;
    assign blue        = out_b_reg;
    assign group_last  = out_glast_reg;
    assign frame_done  = out_fdone_reg;

endmodule

>>> rtl/planar_yuv420_to_rgb_flip.sv
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// input     | in_valid / in_ready            | frame_byte[7:0], frame_start
// result    | out_valid / out_ready          | pixel_index[15:0], red, green, blue,
//           |                                | group_last, frame_done
// config    | psel, penable, pwrite, pready  | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// a luma or u byte is only written to its store
// a v byte is taken, then four reads of the single luma read port follow
// group pixels pass read, product and result registers, one a cycle while out_ready is high
// reset, and every register write, holds in_ready low while sizes settle
// a held pixel with out_ready low freezes reads; next input waits until the group is issued
module planar_yuv420_to_rgb_flip
    import pyrf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // byte stream in
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PIX_W-1:0]  frame_byte,
    input  logic              frame_start,
    // pixels out
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  pixel_index,
    output logic [PIX_W-1:0]  red,
    output logic [PIX_W-1:0]  green,
    output logic [PIX_W-1:0]  blue,
    output logic              group_last,
    output logic              frame_done
);

    // store sizes follow the largest frame
    localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHROMA_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int LA_W         = (LUMA_DEPTH > 1) ? $clog2(LUMA_DEPTH) : 1;
    localparam int CA_W         = (CHROMA_DEPTH > 1) ? $clog2(CHROMA_DEPTH) : 1;

    geom_t            geom;
    logic             cfg_restart, cfg_busy;
    logic             advance;
    pix_tag_t         tag;

    logic             luma_wr_en, luma_rd_en;
    logic [LA_W-1:0]  luma_wr_addr, luma_rd_addr;
    logic [PIX_W-1:0] luma_rd_data;
    logic             u_wr_en, u_rd_en;
    logic [CA_W-1:0]  u_wr_addr, u_rd_addr;
    logic [PIX_W-1:0] u_rd_data;

    // size registers and the frame geometry derived from them
    pyrf_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom),
        .restart (cfg_restart),
        .busy    (cfg_busy)
    );

    // byte position, chroma column and row bases, group read sequencer
    pyrf_seq #(
        .LA_W       (LA_W),
        .CA_W       (CA_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .cfg_restart  (cfg_restart),
        .cfg_busy     (cfg_busy),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_byte   (frame_byte),
        .frame_start  (frame_start),
        .advance      (advance),
        .luma_wr_en   (luma_wr_en),
        .luma_wr_addr (luma_wr_addr),
        .luma_rd_en   (luma_rd_en),
        .luma_rd_addr (luma_rd_addr),
        .u_wr_en      (u_wr_en),
        .u_wr_addr    (u_wr_addr),
        .u_rd_en      (u_rd_en),
        .u_rd_addr    (u_rd_addr),
        .tag          (tag)
    );

    // full luma plane
    pyrf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LUMA_DEPTH),
        .AW    (LA_W)
    ) u_luma_ram (
        .clk     (clk),
        .wr_en   (luma_wr_en),
        .wr_addr (luma_wr_addr),
        .wr_data (frame_byte),
        .rd_en   (luma_rd_en),
        .rd_addr (luma_rd_addr),
        .rd_data (luma_rd_data)
    );

    // quarter-size u plane
    pyrf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (CHROMA_DEPTH),
        .AW    (CA_W)
    ) u_chroma_ram (
        .clk     (clk),
        .wr_en   (u_wr_en),
        .wr_addr (u_wr_addr),
        .wr_data (frame_byte),
        .rd_en   (u_rd_en),
        .rd_addr (u_rd_addr),
        .rd_data (u_rd_data)
    );

    // coefficient products, sums, clamp and the result register
    pyrf_color u_color (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (tag),
        .y_data      (luma_rd_data),
        .u_data      (u_rd_data),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .group_last  (group_last),
        .frame_done  (frame_done)
    );

endmodule
